// ===== rtl/srrip_streaming_aware_replacement_top_defines.svh =====
// Assertion macros shared by the checker of the replacement block.
`ifndef SRRIP_STREAMING_AWARE_REPLACEMENT_TOP_DEFINES_SVH
`define SRRIP_STREAMING_AWARE_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define SRRIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SRRIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/srrip_pkg.sv =====
// Shared constants, row layouts and control structs of the replacement block.
`timescale 1ns / 1ps
package srrip_pkg;

  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int RRPV_WIDTH   = 2;
  localparam int DELTA_WINDOW = 4;

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int ADDR_W = 64;
  localparam int PTR_W  = $clog2(DELTA_WINDOW);
  localparam int CNT_W  = $clog2(DELTA_WINDOW);
  localparam int THR_W  = 2;

  localparam logic [RRPV_WIDTH-1:0] RRPV_DISTANT = {RRPV_WIDTH{1'b1}};
  localparam logic [THR_W-1:0]      THR_RESET = 2'd3;

  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef logic [NUM_WAYS-1:0][RRPV_WIDTH-1:0] rrpv_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0]                   last;
    logic [DELTA_WINDOW-1:0][ADDR_W-1:0] ring;
    logic [PTR_W-1:0]                    ptr;
    logic                                flag;
  } det_row_t;

  localparam int RRPV_ROW_W = $bits(rrpv_row_t);
  localparam int DET_ROW_W  = $bits(det_row_t);

  typedef struct packed {
    logic capture;
    logic delta_en;
    logic eval_en;
    logic write_en;
    logic clear_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== rtl/srrip_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module srrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/srrip_ctrl.sv =====
// Sequencer of the replacement block: clearing pass, then read, delta, evaluate, write.
`timescale 1ns / 1ps
module srrip_ctrl import srrip_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DELTA = 5'b00100,
    S_EVAL  = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd_o.delta_en = 1'b1;
        state_d        = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval_en = 1'b1;
        state_d       = S_WRITE;
      end
      S_WRITE: begin
        // The write and the result load go together, so wait for a free output slot.
        if (status_i.out_free) begin
          cmd_o.write_en = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== rtl/srrip_dp.sv =====
// Datapath of the replacement block: set memories, stream detector, aging and output register.
`timescale 1ns / 1ps
module srrip_dp import srrip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_status_t      status_o,
  input  logic              cfg_we_i,
  input  logic [THR_W-1:0]  cfg_wdata_i,
  input  logic              op_i,
  input  logic [10:0]       set_index_i,
  input  logic [WAY_W-1:0]  way_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              hit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WAY_W-1:0]  victim_way_o,
  output logic              set_streaming_o
);

  logic              op_q;
  logic [SET_W-1:0]  set_q;
  logic [WAY_W-1:0]  way_q;
  logic [ADDR_W-1:0] addr_q;
  logic              hit_q;
  logic [THR_W-1:0]  thr_q;
  logic [SET_W-1:0]  clr_q, clr_d;

  det_row_t  det_rd, det_new_q, det_new_d, det_wr_q, det_wr_d;
  rrpv_row_t rrpv_rd, rrpv_wr_q, rrpv_wr_d;
  logic [WAY_W-1:0] victim_q, victim_d;
  logic             flag_q, flag_d;

  logic             out_valid_q, out_valid_d;
  logic [WAY_W-1:0] out_victim_q;
  logic             out_flag_q;

  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  rrpv_row_t        rrpv_wdata;
  det_row_t         det_wdata;

  // Set memories, written in place after each item or by the clearing pass.
  always_comb begin
    ram_we     = cmd_i.write_en | cmd_i.clear_en;
    ram_waddr  = cmd_i.clear_en ? clr_q : set_q;
    rrpv_wdata = rrpv_wr_q;
    det_wdata  = det_wr_q;
    if (cmd_i.clear_en) begin
      rrpv_wdata = {NUM_WAYS{RRPV_DISTANT}};
      det_wdata  = '0;
    end
  end

  srrip_ram #(.WIDTH(RRPV_ROW_W), .DEPTH(NUM_SETS)) u_rrpv_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rrpv_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (set_index_i[SET_W-1:0]),
    .rdata_o (rrpv_rd)
  );

  srrip_ram #(.WIDTH(DET_ROW_W), .DEPTH(NUM_SETS)) u_det_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (det_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (set_index_i[SET_W-1:0]),
    .rdata_o (det_rd)
  );

  assign clr_d = clr_q + SET_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_q <= clr_d;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Delta stage: fold the new address of an update into the ring.
  always_comb begin
    logic [ADDR_W-1:0] delta;
    delta     = addr_q - det_rd.last;
    det_new_d = det_rd;
    if (op_q == CMD_UPDATE) begin
      det_new_d.last          = addr_q;
      det_new_d.ring[det_rd.ptr] = delta;
      det_new_d.ptr = (det_rd.ptr == PTR_W'(DELTA_WINDOW - 1)) ? '0 : det_rd.ptr + PTR_W'(1);
    end
  end

  function automatic logic is_pos(input logic [ADDR_W-1:0] d);
    return (d != '0) && !d[ADDR_W-1];
  endfunction

  // Evaluate stage: streaming flag, then either aging and victim search or the way update.
  always_comb begin
    logic [CNT_W-1:0]      differing;
    logic                  same_sign;
    logic                  new_flag;
    logic [RRPV_WIDTH-1:0] oldest;
    logic [RRPV_WIDTH-1:0] lift;
    rrpv_row_t             aged;
    differing = '0;
    same_sign = 1'b1;
    for (int i = 1; i < DELTA_WINDOW; i++) begin
      if (det_new_q.ring[i] != det_new_q.ring[0]) begin
        differing = differing + CNT_W'(1);
      end
      if (is_pos(det_new_q.ring[i]) != is_pos(det_new_q.ring[0])) begin
        same_sign = 1'b0;
      end
    end
    new_flag = same_sign && (32'(differing) >= 32'(thr_q));

    oldest = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rrpv_rd[w] > oldest) begin
        oldest = rrpv_rd[w];
      end
    end
    lift = RRPV_DISTANT - oldest;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w] = rrpv_rd[w] + lift;
    end

    det_wr_d  = det_new_q;
    rrpv_wr_d = rrpv_rd;
    victim_d  = '0;
    flag_d    = det_new_q.flag;
    if (op_q == CMD_VICTIM) begin
      rrpv_wr_d = aged;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
        if (aged[w] == RRPV_DISTANT) begin
          victim_d = WAY_W'(w);
        end
      end
    end else begin
      det_wr_d.flag = new_flag;
      flag_d        = new_flag;
      if (hit_q) begin
        rrpv_wr_d[way_q] = '0;
      end else begin
        rrpv_wr_d[way_q] = new_flag ? RRPV_DISTANT : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      set_q  <= set_index_i[SET_W-1:0];
      way_q  <= way_i;
      addr_q <= addr_i;
      hit_q  <= hit_i;
    end
    if (cmd_i.delta_en) begin
      det_new_q <= det_new_d;
    end
    if (cmd_i.eval_en) begin
      det_wr_q  <= det_wr_d;
      rrpv_wr_q <= rrpv_wr_d;
      victim_q  <= victim_d;
      flag_q    <= flag_d;
    end
    if (cmd_i.write_en) begin
      out_victim_q <= victim_q;
      out_flag_q   <= flag_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.write_en) begin
      out_valid_d = 1'b1;
    end
  end

  assign status_o.clear_done = (clr_q == SET_W'(NUM_SETS - 1));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign victim_way_o    = out_victim_q;
  assign set_streaming_o = out_flag_q;

endmodule

// ===== rtl/srrip_streaming_aware_replacement_top.sv =====
// Top level of the SRRIP replacement block with per-set stream detection.
`timescale 1ns / 1ps
// This block keeps a 2-bit re-reference value for each of the 16 ways of 2048 sets and a
// stream detector per set (last address, a ring of four address deltas, a ring pointer
// and a streaming flag). A victim request (cmd 0) returns the lowest way at the maximum
// value, aging the whole set first when no way is there. An update (cmd 1) feeds the
// address into the detector, then sets the way to 0 on a hit, or on a fill to the maximum
// when the set is streaming and to 0 otherwise. Every item yields exactly one result
// transfer carrying the victim way (0 for updates) and the set's streaming flag. Each item
// passes from its input transfer to its result through a registered read of the two set
// memories, the delta step, the evaluation of the set row and its write back; the next item
// is taken on the cycle after the write. A result that is not taken holds the write of the
// following item. After reset the block runs a clearing pass over all 2048 sets, one set
// per cycle, during which no input transfer is taken; writes of stream_threshold are taken
// at any time but belong in idle periods.
module srrip_streaming_aware_replacement_top import srrip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [10:0]       set_index_i,
  input  logic [WAY_W-1:0]  way_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              hit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WAY_W-1:0]  victim_way_o,
  output logic              set_streaming_o,
  input  logic              cfg_we_i,
  input  logic [THR_W-1:0]  cfg_wdata_i
);

  ctrl_cmd_t    ctrl_cmd;
  ctrl_status_t ctrl_status;

  // The sequencer only steps through phases; all state of the sets lives in the datapath.
  srrip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (ctrl_status),
    .cmd_o      (ctrl_cmd)
  );

  srrip_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .status_o        (ctrl_status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (cmd_i),
    .set_index_i     (set_index_i),
    .way_i           (way_i),
    .addr_i          (addr_i),
    .hit_i           (hit_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .victim_way_o    (victim_way_o),
    .set_streaming_o (set_streaming_o)
  );

endmodule

// ===== rtl/srrip_checker.sv =====
// Port-level checker of the replacement block and its bind to the top level.
`timescale 1ns / 1ps
`include "srrip_streaming_aware_replacement_top_defines.svh"
module srrip_checker import srrip_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WAY_W-1:0] victim_way_o,
  input logic             set_streaming_o
);

  // A stalled result stays offered.
  `SRRIP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its payload.
  `SRRIP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(victim_way_o) && $stable(set_streaming_o))

  // One item at a time: the block is busy right after an input transfer.
  `SRRIP_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result appears only out of the busy phase of an item.
  `SRRIP_ASSERT_IMPL(a_result_from_item, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind srrip_streaming_aware_replacement_top srrip_checker u_srrip_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .victim_way_o    (victim_way_o),
  .set_streaming_o (set_streaming_o)
);
